// ===== rtl/core/kfls_pkg.sv =====
`timescale 1ns / 1ps
// kfls_pkg: shared types and constants for the keyed floor lookup scaler
// used by kfls_cell, kfls_mul and keyed_floor_lookup_scaler_core; no dependencies

package kfls_pkg;

    localparam int TableDepthDefault = 64;

    localparam int KeyW    = 23;
    localparam int RateW   = 40;
    localparam int AmountW = 57;
    localparam int MagW    = AmountW - 1;
    localparam int StatusW = 3;
    localparam int ValueW  = 64;
    localparam int ProdW   = MagW + RateW;

    localparam logic [RateW-1:0] LimitReset = 40'd2147483647;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_QUERY  = 1'b1
    } kfls_op_t;

    localparam logic [StatusW-1:0] ST_OK        = 3'd0;
    localparam logic [StatusW-1:0] ST_NEGATIVE  = 3'd1;
    localparam logic [StatusW-1:0] ST_TOO_LARGE = 3'd2;
    localparam logic [StatusW-1:0] ST_DUPLICATE = 3'd3;
    localparam logic [StatusW-1:0] ST_FULL      = 3'd4;

    // request token that walks the cell row, one cell per cycle
    typedef struct packed {
        logic               vld;
        kfls_op_t           op;
        logic [KeyW-1:0]    key;
        logic [RateW-1:0]   rate;
        logic [AmountW-1:0] amount;
        logic [KeyW-1:0]    best_key;
        logic [RateW-1:0]   best_rate;
        logic               have_best;
        logic               exact;
        logic               dup;
        logic               written;
    } kfls_tok_t;

endpackage

// ===== rtl/core/kfls_cell.sv =====
`timescale 1ns / 1ps
// kfls_cell: one table entry plus one stage of the request token row
// depends on kfls_pkg

module kfls_cell (
    input  logic              aclk,
    input  logic              aresetn,
    input  kfls_pkg::kfls_tok_t tok_in,
    output kfls_pkg::kfls_tok_t tok_out
);

    logic [kfls_pkg::KeyW-1:0]  key_reg;
    logic [kfls_pkg::RateW-1:0] rate_reg;
    logic                       valid_reg;
    kfls_pkg::kfls_tok_t        tok_reg;
    kfls_pkg::kfls_tok_t        tok_next;
    logic                       wr_en;

    always_comb begin
        tok_next = tok_in;
        wr_en    = 1'b0;
        if (tok_in.vld) begin
            unique case (tok_in.op)
                kfls_pkg::OP_INSERT: begin
                    if (valid_reg && key_reg == tok_in.key) begin
                        tok_next.dup = 1'b1;
                    end else if (!valid_reg && !tok_in.dup && !tok_in.written) begin
                        // slots fill in order, so every earlier slot was already checked
                        wr_en            = 1'b1;
                        tok_next.written = 1'b1;
                    end
                end
                kfls_pkg::OP_QUERY: begin
                    if (valid_reg && !tok_in.exact) begin
                        if (key_reg == tok_in.key) begin
                            tok_next.exact     = 1'b1;
                            tok_next.have_best = 1'b1;
                            tok_next.best_key  = key_reg;
                            tok_next.best_rate = rate_reg;
                        end else if (key_reg < tok_in.key &&
                                     (!tok_in.have_best || key_reg > tok_in.best_key)) begin
                            tok_next.have_best = 1'b1;
                            tok_next.best_key  = key_reg;
                            tok_next.best_rate = rate_reg;
                        end
                    end
                end
                default: begin
                    tok_next = tok_in;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= 1'b0;
            tok_reg.vld <= 1'b0;
        end else begin
            tok_reg <= tok_next;
            if (wr_en) begin
                valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            key_reg  <= tok_in.key;
            rate_reg <= tok_in.rate;
        end
    end

    assign tok_out = tok_reg;

endmodule

// ===== rtl/core/kfls_mul.sv =====
`timescale 1ns / 1ps
// kfls_mul: two-stage amount times rate multiply with shift by 16 and saturation
// depends on kfls_pkg; holds one request at a time

module kfls_mul (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    input  logic [kfls_pkg::MagW-1:0]     in_a,
    input  logic [kfls_pkg::RateW-1:0]    in_b,
    input  logic [kfls_pkg::StatusW-1:0]  in_status,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic [kfls_pkg::StatusW-1:0]  out_status,
    output logic [kfls_pkg::ValueW-1:0]   out_value
);

    logic                         s1_vld_reg;
    logic [kfls_pkg::StatusW-1:0] s1_status_reg;
    logic [63:0]                  p0_reg;
    logic [39:0]                  p1_reg;
    logic [55:0]                  p2_reg;
    logic [31:0]                  p3_reg;

    logic                         s2_vld_reg;
    logic [kfls_pkg::StatusW-1:0] s2_status_reg;
    logic [kfls_pkg::ProdW-1:0]   sum_reg;
    logic [kfls_pkg::ProdW-1:0]   sum_next;

    logic [31:0] a_lo;
    logic [23:0] a_hi;
    logic [31:0] b_lo;
    logic [7:0]  b_hi;

    assign a_lo = in_a[31:0];
    assign a_hi = in_a[55:32];
    assign b_lo = in_b[31:0];
    assign b_hi = in_b[39:32];

    assign sum_next = {p3_reg, p0_reg}
                    + {24'd0, p1_reg, 32'd0}
                    + {8'd0, p2_reg, 32'd0};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
        end else begin
            s1_vld_reg <= in_valid;
            // only one request is in flight, so stage 2 is free whenever stage 1 is full
            if (s1_vld_reg) begin
                s2_vld_reg <= 1'b1;
            end else if (out_ready) begin
                s2_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid) begin
            s1_status_reg <= in_status;
            p0_reg        <= 64'(a_lo) * 64'(b_lo);
            p1_reg        <= 40'(a_lo) * 40'(b_hi);
            p2_reg        <= 56'(a_hi) * 56'(b_lo);
            p3_reg        <= 32'(a_hi) * 32'(b_hi);
        end
        if (s1_vld_reg) begin
            s2_status_reg <= s1_status_reg;
            sum_reg       <= sum_next;
        end
    end

    assign out_valid  = s2_vld_reg;
    assign out_status = s2_status_reg;
    assign out_value  = (sum_reg[kfls_pkg::ProdW-1:80] != '0) ? '1 : sum_reg[79:16];

endmodule

// ===== rtl/core/keyed_floor_lookup_scaler_core.sv =====
`timescale 1ns / 1ps
// keyed_floor_lookup_scaler_core: date-keyed rate table with floor lookup and scaling
// depends on kfls_pkg, kfls_cell, kfls_mul
//
//  channel   direction  ports                                      moves
//  s_        in         s_valid s_ready s_opcode s_date_key ...    insert / query request
//  m_        out        m_valid m_ready m_status m_scaled_value    result
//  cfg_      in         cfg_valid cfg_ready cfg_data               amount_limit write
//
// a request walks a row of TABLE_DEPTH cells, one cell a cycle, then a finish stage
// and a two-stage multiplier before the result is loaded into the output register
// the next request is accepted once the previous result sits in the output register,
// so requests never overlap; the cell row length sets how long a request takes
// a stall on m_ready holds the result in the multiplier and keeps s_ready low
// synchronous active-low reset empties the table and sets amount_limit to 2147483647

module keyed_floor_lookup_scaler_core #(
    parameter int TABLE_DEPTH = kfls_pkg::TableDepthDefault
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_opcode,
    input  logic [kfls_pkg::KeyW-1:0]           s_date_key,
    input  logic [kfls_pkg::RateW-1:0]          s_entry_rate,
    input  logic signed [kfls_pkg::AmountW-1:0] s_amount,

    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [kfls_pkg::StatusW-1:0]        m_status,
    output logic [kfls_pkg::ValueW-1:0]         m_scaled_value,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [kfls_pkg::RateW-1:0]          cfg_data
);

    kfls_pkg::kfls_tok_t tok [0:TABLE_DEPTH];
    kfls_pkg::kfls_tok_t head;

    logic                          busy_reg;
    logic [kfls_pkg::RateW-1:0]    limit_reg;

    logic                          fin_vld_reg;
    logic [kfls_pkg::StatusW-1:0]  fin_status_reg;
    logic [kfls_pkg::MagW-1:0]     fin_a_reg;
    logic [kfls_pkg::RateW-1:0]    fin_b_reg;
    logic [kfls_pkg::StatusW-1:0]  fin_status_next;
    logic [kfls_pkg::MagW-1:0]     fin_a_next;
    logic [kfls_pkg::RateW-1:0]    fin_b_next;

    logic                          mul_valid;
    logic                          mul_ready;
    logic [kfls_pkg::StatusW-1:0]  mul_status;
    logic [kfls_pkg::ValueW-1:0]   mul_value;

    logic                          m_valid_reg;
    logic [kfls_pkg::StatusW-1:0]  m_status_reg;
    logic [kfls_pkg::ValueW-1:0]   m_value_reg;

    logic                          s_accept;
    logic                          res_load;
    kfls_pkg::kfls_tok_t           tail;

    assign s_ready   = !busy_reg;
    assign s_accept  = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    always_comb begin
        head           = '0;
        head.vld       = s_accept;
        head.op        = kfls_pkg::kfls_op_t'(s_opcode);
        head.key       = s_date_key;
        head.rate      = s_entry_rate;
        head.amount    = $unsigned(s_amount);
    end

    assign tok[0] = head;

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        kfls_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .tok_in  (tok[g]),
            .tok_out (tok[g+1])
        );
    end

    assign tail = tok[TABLE_DEPTH];

    // status and multiplier operands once the request has seen every entry
    always_comb begin
        fin_status_next = kfls_pkg::ST_OK;
        fin_a_next      = '0;
        fin_b_next      = '0;
        unique case (tail.op)
            kfls_pkg::OP_INSERT: begin
                priority if (tail.dup) begin
                    fin_status_next = kfls_pkg::ST_DUPLICATE;
                end else if (!tail.written) begin
                    fin_status_next = kfls_pkg::ST_FULL;
                end else begin
                    fin_status_next = kfls_pkg::ST_OK;
                end
            end
            kfls_pkg::OP_QUERY: begin
                priority if (tail.amount[kfls_pkg::AmountW-1]) begin
                    fin_status_next = kfls_pkg::ST_NEGATIVE;
                end else if (tail.amount[kfls_pkg::MagW-1:16] > limit_reg) begin
                    fin_status_next = kfls_pkg::ST_TOO_LARGE;
                end else begin
                    fin_status_next = kfls_pkg::ST_OK;
                    fin_a_next      = tail.amount[kfls_pkg::MagW-1:0];
                    fin_b_next      = tail.have_best ? tail.best_rate : '0;
                end
            end
            default: begin
                fin_status_next = kfls_pkg::ST_OK;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fin_vld_reg <= 1'b0;
        end else begin
            fin_vld_reg <= tail.vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (tail.vld) begin
            fin_status_reg <= fin_status_next;
            fin_a_reg      <= fin_a_next;
            fin_b_reg      <= fin_b_next;
        end
    end

    assign mul_ready = !m_valid_reg || m_ready;

    kfls_mul u_mul (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (fin_vld_reg),
        .in_a       (fin_a_reg),
        .in_b       (fin_b_reg),
        .in_status  (fin_status_reg),
        .out_ready  (mul_ready),
        .out_valid  (mul_valid),
        .out_status (mul_status),
        .out_value  (mul_value)
    );

    assign res_load = mul_valid && mul_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            limit_reg   <= kfls_pkg::LimitReset;
        end else begin
            if (s_accept) begin
                busy_reg <= 1'b1;
            end else if (res_load) begin
                busy_reg <= 1'b0;
            end
            if (res_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready) begin
                limit_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (res_load) begin
            m_status_reg <= mul_status;
            m_value_reg  <= mul_value;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_scaled_value = m_value_reg;

endmodule
